>>> hdl/ryc_pkg.sv
// Shared types, constants and arithmetic helpers for the RGB to YUV 4:2:0 pair converter.
package ryc_pkg;

  localparam int QUEUE_DEPTH = 4;  // power of two, pointers wrap naturally
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int LPW         = 11;

  localparam logic [LPW-1:0] LINE_PAIRS_RESET = 11'd360;
  localparam logic [7:0]     LUMA_OFFSET      = 8'd16;
  localparam logic [7:0]     CHROMA_OFFSET    = 8'd128;

  localparam logic [15:0] KY_R   = 16'd16829;
  localparam logic [15:0] KY_G   = 16'd33039;
  localparam logic [15:0] KY_B   = 16'd6416;

  localparam logic [15:0] KCB_B  = 16'd14383;
  localparam logic [15:0] KCB_R  = 16'd4853;
  localparam logic [15:0] KCB_G  = 16'd9530;
  localparam logic [15:0] KCR_R  = 16'd14386;
  localparam logic [15:0] KCR_G  = 16'd12046;
  localparam logic [15:0] KCR_B  = 16'd2340;

  localparam logic [15:0] KCBH_B = 16'd7191;
  localparam logic [15:0] KCBH_R = 16'd2426;
  localparam logic [15:0] KCBH_G = 16'd4765;
  localparam logic [15:0] KCRH_R = 16'd7193;
  localparam logic [15:0] KCRH_G = 16'd6023;
  localparam logic [15:0] KCRH_B = 16'd1170;

  typedef struct packed {
    logic        frame_start;
    logic        chroma_en;
    logic [23:0] luma_a;
    logic [23:0] luma_b;
    logic [15:0] luma_ab;
    logic [23:0] cb_sum;
    logic [23:0] cr_sum;
    logic [21:0] cb_half;
    logic [21:0] cr_half;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [23:0] prod(logic [15:0] k, logic [7:0] x);
    return 24'(k) * 24'(x);
  endfunction

  // k_pos*p - k_n1*n1 - k_n2*n2, modulo 2^24
  function automatic logic [23:0] wsum(logic [15:0] k_pos, logic [7:0] p,
                                       logic [15:0] k_n1, logic [7:0] n1,
                                       logic [15:0] k_n2, logic [7:0] n2);
    return prod(k_pos, p) - prod(k_n1, n1) - prod(k_n2, n2);
  endfunction

  function automatic logic [23:0] luma_sum(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return prod(KY_R, r) + prod(KY_G, g) + prod(KY_B, b);
  endfunction

endpackage

>>> hdl/ryc_front.sv
// Front end: input transaction acceptance, line position tracking and product sums.
module ryc_front #(
  parameter int MAX_LINE_PAIRS = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [ryc_pkg::LPW-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  input  logic [7:0]             red_first_i,
  input  logic [7:0]             green_first_i,
  input  logic [7:0]             blue_first_i,
  input  logic [7:0]             red_second_i,
  input  logic [7:0]             green_second_i,
  input  logic [7:0]             blue_second_i,
  input  logic                   frame_start_i,
  output logic                   in_stall_o,
  input  ryc_pkg::q_status_t     q_status_i,
  output logic                   q_push_o,
  output ryc_pkg::work_t         q_data_o
);

  localparam int CW   = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
  localparam int CMPW = (CW + 1 > ryc_pkg::LPW) ? CW + 1 : ryc_pkg::LPW;

  logic [ryc_pkg::LPW-1:0] line_pairs_q;
  logic [CW-1:0]           col_q, col_d, col_base;
  logic                    row_odd_q, row_odd_d, row_base;
  logic                    front_valid_q, front_valid_d;
  ryc_pkg::work_t          work_q, work_d;
  logic [CMPW-1:0]         col_inc, lp_ext, limit;
  logic                    wrap, accept, push;

  assign push       = front_valid_q && !q_status_i.full;
  assign in_stall_o = front_valid_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = push;
  assign q_data_o   = work_q;

  always_comb begin
    col_base = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? 1'b0 : row_odd_q;
    col_inc  = CMPW'(col_base) + CMPW'(1);
    lp_ext   = CMPW'(line_pairs_q);
    if (lp_ext == '0) begin
      limit = CMPW'(1);
    end else if (lp_ext > CMPW'(MAX_LINE_PAIRS)) begin
      limit = CMPW'(MAX_LINE_PAIRS);
    end else begin
      limit = lp_ext;
    end
    wrap = (col_inc >= limit);

    col_d         = col_q;
    row_odd_d     = row_odd_q;
    front_valid_d = front_valid_q;
    if (accept) begin
      col_d         = wrap ? '0 : col_inc[CW-1:0];
      row_odd_d     = wrap ? !row_base : row_base;
      front_valid_d = 1'b1;
    end else if (push) begin
      front_valid_d = 1'b0;
    end

    work_d.frame_start = frame_start_i;
    work_d.chroma_en   = !row_base;
    work_d.luma_a      = ryc_pkg::luma_sum(red_first_i, green_first_i, blue_first_i);
    work_d.luma_b      = ryc_pkg::luma_sum(red_second_i, green_second_i, blue_second_i);
    work_d.luma_ab     = work_d.luma_a[15:0] + work_d.luma_b[15:0];
    work_d.cb_half     = 22'(ryc_pkg::wsum(ryc_pkg::KCBH_B, blue_second_i,
                                           ryc_pkg::KCBH_R, red_second_i,
                                           ryc_pkg::KCBH_G, green_second_i));
    work_d.cr_half     = 22'(ryc_pkg::wsum(ryc_pkg::KCRH_R, red_second_i,
                                           ryc_pkg::KCRH_G, green_second_i,
                                           ryc_pkg::KCRH_B, blue_second_i));
    work_d.cb_sum      = ryc_pkg::wsum(ryc_pkg::KCB_B, blue_first_i,
                                       ryc_pkg::KCB_R, red_first_i,
                                       ryc_pkg::KCB_G, green_first_i)
                       + {{2{work_d.cb_half[21]}}, work_d.cb_half};
    work_d.cr_sum      = ryc_pkg::wsum(ryc_pkg::KCR_R, red_first_i,
                                       ryc_pkg::KCR_G, green_first_i,
                                       ryc_pkg::KCR_B, blue_first_i)
                       + {{2{work_d.cr_half[21]}}, work_d.cr_half};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pairs_q  <= ryc_pkg::LINE_PAIRS_RESET;
      col_q         <= '0;
      row_odd_q     <= 1'b0;
      front_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        line_pairs_q <= cfg_data_i;
      end
      col_q         <= col_d;
      row_odd_q     <= row_odd_d;
      front_valid_q <= front_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_q <= work_d;
    end
  end

endmodule

>>> hdl/ryc_queue.sv
// Small register queue between the front and back ends.
module ryc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ryc_pkg::work_t     push_data_i,
  input  logic               pop_i,
  output ryc_pkg::work_t     pop_data_o,
  output ryc_pkg::q_status_t status_o
);

  ryc_pkg::work_t          mem [ryc_pkg::QUEUE_DEPTH];
  logic [ryc_pkg::QAW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ryc_pkg::QAW:0]   count_q, count_d;
  logic                    do_push, do_pop;

  assign status_o.full  = (count_q == (ryc_pkg::QAW+1)'(ryc_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/ryc_back.sv
// Back end: fraction carries, chroma tap state and the output register.
module ryc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ryc_pkg::q_status_t q_status_i,
  input  ryc_pkg::work_t     q_data_i,
  output logic               q_pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         luma_first_o,
  output logic [7:0]         luma_second_o,
  output logic               chroma_valid_o,
  output logic [7:0]         chroma_blue_o,
  output logic [7:0]         chroma_red_o
);

  logic [15:0] luma_frac_q, luma_frac_d, blue_frac_q, blue_frac_d, red_frac_q, red_frac_d;
  logic [21:0] prev_cb_q, prev_cb_d, prev_cr_q, prev_cr_d;
  logic [15:0] lf_eff, bf_eff, rf_eff;
  logic [21:0] pb_eff, pr_eff;
  logic [23:0] ya, yb, cb, cr;
  logic        out_valid_q, out_valid_d, pop;
  logic [7:0]  luma_first_q, luma_first_d, luma_second_q, luma_second_d;
  logic        chroma_valid_q, chroma_valid_d;
  logic [7:0]  chroma_blue_q, chroma_blue_d, chroma_red_q, chroma_red_d;

  assign pop     = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  always_comb begin
    lf_eff = q_data_i.frame_start ? '0 : luma_frac_q;
    bf_eff = q_data_i.frame_start ? '0 : blue_frac_q;
    rf_eff = q_data_i.frame_start ? '0 : red_frac_q;
    pb_eff = q_data_i.frame_start ? '0 : prev_cb_q;
    pr_eff = q_data_i.frame_start ? '0 : prev_cr_q;

    ya = q_data_i.luma_a + {8'b0, lf_eff};
    yb = q_data_i.luma_b + {8'b0, ya[15:0]};
    cb = q_data_i.cb_sum + {{2{pb_eff[21]}}, pb_eff} + {8'b0, bf_eff};
    cr = q_data_i.cr_sum + {{2{pr_eff[21]}}, pr_eff} + {8'b0, rf_eff};

    luma_frac_d    = luma_frac_q;
    blue_frac_d    = blue_frac_q;
    red_frac_d     = red_frac_q;
    prev_cb_d      = prev_cb_q;
    prev_cr_d      = prev_cr_q;
    out_valid_d    = out_valid_q && out_stall_i;
    luma_first_d   = luma_first_q;
    luma_second_d  = luma_second_q;
    chroma_valid_d = chroma_valid_q;
    chroma_blue_d  = chroma_blue_q;
    chroma_red_d   = chroma_red_q;

    if (pop) begin
      out_valid_d   = 1'b1;
      luma_frac_d   = q_data_i.luma_ab + lf_eff;
      luma_first_d  = ya[23:16] + ryc_pkg::LUMA_OFFSET;
      luma_second_d = yb[23:16] + ryc_pkg::LUMA_OFFSET;
      blue_frac_d   = bf_eff;
      red_frac_d    = rf_eff;
      prev_cb_d     = pb_eff;
      prev_cr_d     = pr_eff;
      if (q_data_i.chroma_en) begin
        chroma_valid_d = 1'b1;
        chroma_blue_d  = cb[23:16] + ryc_pkg::CHROMA_OFFSET;
        chroma_red_d   = cr[23:16] + ryc_pkg::CHROMA_OFFSET;
        blue_frac_d    = cb[15:0];
        red_frac_d     = cr[15:0];
        prev_cb_d      = q_data_i.cb_half;
        prev_cr_d      = q_data_i.cr_half;
      end else begin
        chroma_valid_d = 1'b0;
        chroma_blue_d  = '0;
        chroma_red_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      luma_frac_q <= '0;
      blue_frac_q <= '0;
      red_frac_q  <= '0;
      prev_cb_q   <= '0;
      prev_cr_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      luma_frac_q <= luma_frac_d;
      blue_frac_q <= blue_frac_d;
      red_frac_q  <= red_frac_d;
      prev_cb_q   <= prev_cb_d;
      prev_cr_q   <= prev_cr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    luma_first_q   <= luma_first_d;
    luma_second_q  <= luma_second_d;
    chroma_valid_q <= chroma_valid_d;
    chroma_blue_q  <= chroma_blue_d;
    chroma_red_q   <= chroma_red_d;
  end

  assign out_valid_o    = out_valid_q;
  assign luma_first_o   = luma_first_q;
  assign luma_second_o  = luma_second_q;
  assign chroma_valid_o = chroma_valid_q;
  assign chroma_blue_o  = chroma_blue_q;
  assign chroma_red_o   = chroma_red_q;

endmodule

>>> hdl/rgb_to_yuv420_pair_converter_unit.sv
// Top level of the RGB888 pair to YCbCr 4:2:0 converter.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   two RGB888 pixels, frame_start_i
//  out      output     out_valid_o / out_stall_i luma pair, chroma flag, Cb, Cr
//  cfg      input      cfg_valid_i / cfg_ready_o line_pairs_i
//
// One transaction per clock sustained while the output is not stalled; a result
// passes through the front register, a queue entry and the output register.
// The fraction carry adders in the back end set the register feedback loop.
// A four-entry queue decouples the front end from output stalls; in_stall_o
// rises only when the queue and the front register are both full.
// Reset clears carries, line position and queue; line_pairs resets to 360.
module rgb_to_yuv420_pair_converter_unit #(
  parameter int MAX_LINE_PAIRS = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [ryc_pkg::LPW-1:0] line_pairs_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              red_first_i,
  input  logic [7:0]              green_first_i,
  input  logic [7:0]              blue_first_i,
  input  logic [7:0]              red_second_i,
  input  logic [7:0]              green_second_i,
  input  logic [7:0]              blue_second_i,
  input  logic                    frame_start_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              luma_first_o,
  output logic [7:0]              luma_second_o,
  output logic                    chroma_valid_o,
  output logic [7:0]              chroma_blue_o,
  output logic [7:0]              chroma_red_o
);

  ryc_pkg::q_status_t q_status;
  ryc_pkg::work_t     push_data, pop_data;
  logic               push, pop;

  assign cfg_ready_o = 1'b1;

  ryc_front #(
    .MAX_LINE_PAIRS(MAX_LINE_PAIRS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (line_pairs_i),
    .in_valid_i,
    .red_first_i,
    .green_first_i,
    .blue_first_i,
    .red_second_i,
    .green_second_i,
    .blue_second_i,
    .frame_start_i,
    .in_stall_o,
    .q_status_i     (q_status),
    .q_push_o       (push),
    .q_data_o       (push_data)
  );

  ryc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  ryc_back u_back (
    .clk_i,
    .rst_ni,
    .q_status_i (q_status),
    .q_data_i   (pop_data),
    .q_pop_o    (pop),
    .out_stall_i,
    .out_valid_o,
    .luma_first_o,
    .luma_second_o,
    .chroma_valid_o,
    .chroma_blue_o,
    .chroma_red_o
  );

endmodule

>>> hdl/ryc_checker.sv
// Port-level checks for the converter top level, bound to every instance.
module ryc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       chroma_valid_o,
  input logic [7:0] chroma_blue_o,
  input logic [7:0] chroma_red_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  a_odd_row_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chroma_valid_o |-> chroma_blue_o == 8'd0 && chroma_red_o == 8'd0)
    else $error("chroma bytes nonzero on a row without chroma");

  a_stall_needs_full_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while output register empty");

  a_stall_rise_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_stall_i))
    else $error("input stall rose without output backpressure");

endmodule

bind rgb_to_yuv420_pair_converter_unit ryc_checker u_ryc_checker (.*);

>>> dv/rgb_to_yuv420_pair_converter_unit_tb.sv
// Self-checking testbench for the RGB888 pair to YCbCr 4:2:0 converter.
module rgb_to_yuv420_pair_converter_unit_tb;

  localparam int MAX_PAIRS  = 1024;
  localparam int WDOG_LIMIT = 4000;
  localparam int LONG_HOLD  = 48;

  typedef struct packed {
    logic [7:0] r1;
    logic [7:0] g1;
    logic [7:0] b1;
    logic [7:0] r2;
    logic [7:0] g2;
    logic [7:0] b2;
    logic       fs;
  } rgb_pair_t;

  typedef struct packed {
    logic [7:0] y1;
    logic [7:0] y2;
    logic       cv;
    logic [7:0] cb;
    logic [7:0] cr;
  } yuv_out_t;

  class yuv_pair_scoreboard;
    logic [ryc_pkg::LPW-1:0] line_pairs;
    logic [15:0] luma_frac;
    logic [15:0] cb_frac;
    logic [15:0] cr_frac;
    logic [21:0] cb_prev_half;
    logic [21:0] cr_prev_half;
    int unsigned column;
    bit          odd_row;
    yuv_out_t    expected_yuv[$];
    int          errors;

    function new();
      line_pairs   = ryc_pkg::LINE_PAIRS_RESET;
      luma_frac    = '0;
      cb_frac      = '0;
      cr_frac      = '0;
      cb_prev_half = '0;
      cr_prev_half = '0;
      column       = 0;
      odd_row      = 0;
      errors       = 0;
    endfunction

    function void set_line_pairs(logic [ryc_pkg::LPW-1:0] v);
      line_pairs = v;
    endfunction

    function int pending();
      return expected_yuv.size();
    endfunction

    function yuv_out_t convert_pair(rgb_pair_t p);
      logic [31:0] ya, yb, cbf, crf, cbh, crh, cb, cr;
      int unsigned lim;
      yuv_out_t o;
      if (p.fs) begin
        luma_frac    = '0;
        cb_frac      = '0;
        cr_frac      = '0;
        cb_prev_half = '0;
        cr_prev_half = '0;
        column       = 0;
        odd_row      = 0;
      end
      ya = 32'd16829 * 32'(p.r1) + 32'd33039 * 32'(p.g1) + 32'd6416 * 32'(p.b1)
           + 32'(luma_frac);
      yb = 32'd16829 * 32'(p.r2) + 32'd33039 * 32'(p.g2) + 32'd6416 * 32'(p.b2)
           + 32'(ya[15:0]);
      luma_frac = yb[15:0];
      o.y1 = ya[23:16] + 8'd16;
      o.y2 = yb[23:16] + 8'd16;
      if (!odd_row) begin
        cbf = 32'd14383 * 32'(p.b1) - 32'd4853 * 32'(p.r1) - 32'd9530 * 32'(p.g1);
        crf = 32'd14386 * 32'(p.r1) - 32'd12046 * 32'(p.g1) - 32'd2340 * 32'(p.b1);
        cbh = 32'd7191 * 32'(p.b2) - 32'd2426 * 32'(p.r2) - 32'd4765 * 32'(p.g2);
        crh = 32'd7193 * 32'(p.r2) - 32'd6023 * 32'(p.g2) - 32'd1170 * 32'(p.b2);
        cb = {{10{cb_prev_half[21]}}, cb_prev_half} + cbf + cbh + 32'(cb_frac);
        cr = {{10{cr_prev_half[21]}}, cr_prev_half} + crf + crh + 32'(cr_frac);
        cb_frac      = cb[15:0];
        cr_frac      = cr[15:0];
        cb_prev_half = cbh[21:0];
        cr_prev_half = crh[21:0];
        o.cv = 1'b1;
        o.cb = cb[23:16] + 8'd128;
        o.cr = cr[23:16] + 8'd128;
      end else begin
        o.cv = 1'b0;
        o.cb = '0;
        o.cr = '0;
      end
      lim = line_pairs;
      if (lim == 0) lim = 1;
      if (lim > MAX_PAIRS) lim = MAX_PAIRS;
      column = column + 1;
      if (column >= lim) begin
        column  = 0;
        odd_row = !odd_row;
      end
      return o;
    endfunction

    function void note_pair(rgb_pair_t p);
      expected_yuv.push_back(convert_pair(p));
    endfunction

    function void field_check(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_pixels(yuv_out_t act);
      yuv_out_t e;
      if (expected_yuv.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual y=%0d/%0d cv=%0d cb=%0d cr=%0d",
                 $time, act.y1, act.y2, act.cv, act.cb, act.cr);
        return;
      end
      e = expected_yuv.pop_front();
      field_check("luma_first", e.y1, act.y1);
      field_check("luma_second", e.y2, act.y2);
      field_check("chroma_valid", e.cv, act.cv);
      field_check("chroma_blue", e.cb, act.cb);
      field_check("chroma_red", e.cr, act.cr);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [ryc_pkg::LPW-1:0] line_pairs;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              red_first, green_first, blue_first;
  logic [7:0]              red_second, green_second, blue_second;
  logic                    frame_start;
  logic                    out_valid;
  logic                    out_stall;
  logic [7:0]              luma_first, luma_second;
  logic                    chroma_valid;
  logic [7:0]              chroma_blue, chroma_red;

  yuv_pair_scoreboard sb = new();
  bit send_idle;
  bit recv_idle;
  int hold_cycles;
  int quiet_cycles;

  rgb_to_yuv420_pair_converter_unit #(
    .MAX_LINE_PAIRS(MAX_PAIRS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .line_pairs_i   (line_pairs),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .red_first_i    (red_first),
    .green_first_i  (green_first),
    .blue_first_i   (blue_first),
    .red_second_i   (red_second),
    .green_second_i (green_second),
    .blue_second_i  (blue_second),
    .frame_start_i  (frame_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .luma_first_o   (luma_first),
    .luma_second_o  (luma_second),
    .chroma_valid_o (chroma_valid),
    .chroma_blue_o  (chroma_blue),
    .chroma_red_o   (chroma_red)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_pixels({luma_first, luma_second, chroma_valid, chroma_blue, chroma_red});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
        $display("rgb_to_yuv420_pair_converter_unit_tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random stall per transaction, one long hold on request
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = recv_idle ? $urandom_range(0, 12) : 0;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  task automatic send_pair(rgb_pair_t p);
    int gap;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    {red_first, green_first, blue_first} <= {p.r1, p.g1, p.b1};
    {red_second, green_second, blue_second} <= {p.r2, p.g2, p.b2};
    frame_start <= p.fs;
    in_valid    <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_pair(p);
  endtask

  task automatic write_line_pairs(logic [ryc_pkg::LPW-1:0] v);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    line_pairs <= v;
    cfg_valid  <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.set_line_pairs(v);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic rgb_pair_t mk(int r1, int g1, int b1, int r2, int g2, int b2, bit fs);
    rgb_pair_t p;
    p = {8'(r1), 8'(g1), 8'(b1), 8'(r2), 8'(g2), 8'(b2), fs};
    return p;
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_phase(int n, int fs_odds, bit first_fs);
    rgb_pair_t p;
    for (int i = 0; i < n; i++) begin
      if (i % 128 == 127) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      p.r1 = pick_channel();
      p.g1 = pick_channel();
      p.b1 = pick_channel();
      p.r2 = pick_channel();
      p.g2 = pick_channel();
      p.b2 = pick_channel();
      p.fs = (i == 0) ? first_fs : (fs_odds > 0 && $urandom_range(1, fs_odds) == 1);
      send_pair(p);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid    = 1'b0;
    line_pairs   = '0;
    in_valid     = 1'b0;
    red_first    = '0;
    green_first  = '0;
    blue_first   = '0;
    red_second   = '0;
    green_second = '0;
    blue_second  = '0;
    frame_start  = 1'b0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    hold_cycles  = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // default line length, channel extremes
    send_pair(mk(0, 0, 0, 0, 0, 0, 1));
    send_pair(mk(255, 255, 255, 255, 255, 255, 0));
    send_pair(mk(255, 0, 0, 0, 0, 0, 0));
    send_pair(mk(0, 255, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 255, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, 255, 255, 255, 0));
    send_pair(mk(255, 255, 255, 0, 0, 0, 0));
    send_pair(mk(255, 0, 255, 0, 255, 0, 0));

    // two pairs per line: odd rows, frame start in the middle of an odd row
    write_line_pairs(11'd2);
    send_pair(mk(0, 0, 255, 255, 255, 0, 1));
    send_pair(mk(255, 255, 0, 0, 0, 255, 0));
    send_pair(mk(128, 128, 128, 128, 128, 128, 0));
    send_pair(mk(255, 0, 0, 0, 255, 0, 0));
    send_pair(mk(0, 255, 0, 255, 0, 255, 0));
    send_pair(mk(255, 0, 0, 0, 0, 255, 0));
    send_pair(mk(1, 2, 3, 4, 5, 6, 0));
    send_pair(mk(170, 85, 170, 85, 170, 85, 1));
    send_pair(mk(85, 170, 85, 170, 85, 170, 0));
    send_pair(mk(255, 255, 255, 255, 255, 255, 0));
    send_pair(mk(0, 0, 255, 0, 0, 255, 0));

    // zero length behaves as one pair per line
    write_line_pairs(11'd0);
    send_pair(mk(0, 0, 255, 255, 0, 0, 1));
    send_pair(mk(255, 0, 0, 0, 0, 255, 0));
    send_pair(mk(0, 0, 255, 0, 0, 255, 0));
    send_pair(mk(255, 255, 0, 0, 255, 255, 0));

    // oversize length clamps to the maximum: one full line and a bit
    write_line_pairs(11'd2047);
    run_phase(MAX_PAIRS + 12, 0, 1'b1);

    write_line_pairs(11'(MAX_PAIRS));
    run_phase(30, 0, 1'b0);

    write_line_pairs(11'd1);
    run_phase(30, 32, 1'b0);

    // backpressure: receiver holds off while the sender keeps pushing
    write_line_pairs(11'($urandom_range(2, 9)));
    send_idle   = 1'b0;
    hold_cycles = LONG_HOLD;
    run_phase(40, 64, 1'b0);

    for (int k = 0; k < 6; k++) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      write_line_pairs(11'($urandom_range(1, 9)));
      run_phase(25, 64, 1'b0);
    end

    write_line_pairs(ryc_pkg::LINE_PAIRS_RESET);
    run_phase(20, 0, 1'b0);

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rgb_to_yuv420_pair_converter_unit_tb OK");
    end else begin
      $display("rgb_to_yuv420_pair_converter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
